// File: design/dba_pkg.sv
package dba_pkg;

  localparam int DISK_BLOCKS = 64;

  // field widths of the request and result items
  localparam int KIND_W = 2;
  localparam int CNT_W  = 7;
  localparam int BLK_W  = 6;
  localparam int SIZE_W = 7;
  localparam int FC_W   = 7;
  localparam int HC_W   = 6;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXTEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic MODE_CONTIG = 1'b0;
  localparam logic MODE_LINKED = 1'b1;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DECIDE,
    OP_FAIL,
    OP_EXTCHK,
    OP_FIT,
    OP_CFREE,
    OP_TAKE,
    OP_LTAKE,
    OP_LEND,
    OP_WREAD,
    OP_WSTEP,
    OP_COUNT,
    OP_EMIT,
    OP_EWAIT
  } dba_op_e;

  typedef enum logic [2:0] {
    REQ_NONE,
    REQ_CEXT,
    REQ_CFIT,
    REQ_LTAKE,
    REQ_FAIL,
    REQ_CFREE,
    REQ_WALK
  } dba_req_e;

  typedef struct packed {
    dba_op_e op;
  } dba_cmd_t;

  typedef struct packed {
    dba_req_e req;
    logic     in_fire;
    logic     done;
    logic     hit;
    logic     fresh;
    logic     reloc;
    logic     out_fire;
    logic     out_last;
  } dba_sts_t;

endpackage

// File: design/dba_req_if.sv
interface dba_req_if;
  logic                       valid;
  logic                       ready;
  logic [dba_pkg::KIND_W-1:0] kind;
  logic [dba_pkg::CNT_W-1:0]  block_count;
  logic [dba_pkg::BLK_W-1:0]  anchor_block;
  logic [dba_pkg::SIZE_W-1:0] current_size;

  modport source (output valid, kind, block_count, anchor_block, current_size, input ready);
  modport sink (input valid, kind, block_count, anchor_block, current_size, output ready);
endinterface

// File: design/dba_rsp_if.sv
interface dba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic                      block_valid;
  logic [dba_pkg::BLK_W-1:0] block;
  logic                      last;
  logic [dba_pkg::FC_W-1:0]  free_count;
  logic [dba_pkg::HC_W-1:0]  hole_count;

  modport source (output valid, status, block_valid, block, last, free_count, hole_count,
                  input ready);
  modport sink (input valid, status, block_valid, block, last, free_count, hole_count,
                output ready);
endinterface

// File: design/dba_ram.sv
module dba_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/dba_ctrl.sv
module dba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dba_pkg::dba_sts_t sts_i,
  output dba_pkg::dba_cmd_t cmd_o
);
  import dba_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_FAIL   = 4'd2;
  localparam logic [3:0] S_EXTCHK = 4'd3;
  localparam logic [3:0] S_FIT    = 4'd4;
  localparam logic [3:0] S_CFREE  = 4'd5;
  localparam logic [3:0] S_TAKE   = 4'd6;
  localparam logic [3:0] S_LTAKE  = 4'd7;
  localparam logic [3:0] S_LEND   = 4'd8;
  localparam logic [3:0] S_WREAD  = 4'd9;
  localparam logic [3:0] S_WSTEP  = 4'd10;
  localparam logic [3:0] S_COUNT  = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;
  localparam logic [3:0] S_EWAIT  = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (sts_i.in_fire) state_d = S_DECIDE;
      S_DECIDE: begin
        unique case (sts_i.req)
          REQ_CEXT:  state_d = S_EXTCHK;
          REQ_CFIT:  state_d = S_FIT;
          REQ_LTAKE: state_d = S_LTAKE;
          REQ_FAIL:  state_d = S_FAIL;
          REQ_CFREE: state_d = S_CFREE;
          REQ_WALK:  state_d = S_WREAD;
          default:   state_d = S_COUNT;
        endcase
      end
      S_FAIL:   state_d = S_COUNT;
      S_EXTCHK: if (sts_i.done) state_d = sts_i.hit ? S_FIT : S_TAKE;
      S_FIT: begin
        if (sts_i.done) begin
          if (!sts_i.hit)       state_d = S_COUNT;
          else if (sts_i.fresh) state_d = S_TAKE;
          else                  state_d = S_CFREE;
        end
      end
      // releasing the old run comes before taking the relocated one
      S_CFREE:  if (sts_i.done) state_d = sts_i.reloc ? S_TAKE : S_COUNT;
      S_TAKE:   if (sts_i.done) state_d = S_COUNT;
      S_LTAKE:  if (sts_i.done) state_d = S_LEND;
      S_LEND:   state_d = S_COUNT;
      S_WREAD:  state_d = sts_i.done ? S_COUNT : S_WSTEP;
      S_WSTEP:  state_d = S_WREAD;
      S_COUNT:  if (sts_i.done) state_d = S_EMIT;
      S_EMIT:   if (sts_i.hit) state_d = S_EWAIT;
      S_EWAIT: begin
        if (sts_i.out_fire) state_d = sts_i.out_last ? S_IDLE : S_EMIT;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:   cmd_o.op = OP_IDLE;
      S_DECIDE: cmd_o.op = OP_DECIDE;
      S_FAIL:   cmd_o.op = OP_FAIL;
      S_EXTCHK: cmd_o.op = OP_EXTCHK;
      S_FIT:    cmd_o.op = OP_FIT;
      S_CFREE:  cmd_o.op = OP_CFREE;
      S_TAKE:   cmd_o.op = OP_TAKE;
      S_LTAKE:  cmd_o.op = OP_LTAKE;
      S_LEND:   cmd_o.op = OP_LEND;
      S_WREAD:  cmd_o.op = OP_WREAD;
      S_WSTEP:  cmd_o.op = OP_WSTEP;
      S_COUNT:  cmd_o.op = OP_COUNT;
      S_EMIT:   cmd_o.op = OP_EMIT;
      S_EWAIT:  cmd_o.op = OP_EWAIT;
      default:  cmd_o.op = OP_IDLE;
    endcase
  end

endmodule

// File: design/dba_dp.sv
module dba_dp #(
  parameter int DiskBlocks = dba_pkg::DISK_BLOCKS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  dba_pkg::dba_cmd_t cmd_i,
  output dba_pkg::dba_sts_t sts_o,
  dba_req_if.sink           req_i,
  dba_rsp_if.source         rsp_o
);
  import dba_pkg::*;

  localparam int IW  = $clog2(DiskBlocks);
  localparam int CW  = $clog2(DiskBlocks + 1);
  localparam int LW  = $clog2(DiskBlocks + 2);
  localparam int SW  = ((CW > 7) ? CW : 7) + 2;
  localparam int CUW = (LW > BLK_W) ? LW : BLK_W;
  localparam logic [LW-1:0] EndMark  = LW'(DiskBlocks);
  localparam logic [LW-1:0] FreeMark = LW'(DiskBlocks + 1);
  localparam logic [SW-1:0] NBlk     = SW'(DiskBlocks);
  localparam logic [SW-1:0] NLast    = SW'(DiskBlocks - 1);

  // control state
  logic                  mode_q, mode_d;
  logic                  fresh_q, fresh_d;
  logic                  fail_q, fail_d;
  logic                  reloc_q, reloc_d;
  logic                  have_prev_q, have_prev_d;
  logic                  pbit_q, pbit_d;
  logic                  ov_q, ov_d;
  logic [SW-1:0]         k_q, k_d;
  logic [SW-1:0]         run_q, run_d;
  logic [CW-1:0]         n_q, n_d;
  logic [CW-1:0]         e_q, e_d;
  logic [CW-1:0]         steps_q, steps_d;
  logic [CW-1:0]         fc_q, fc_d;
  logic [CW-1:0]         hc_q, hc_d;
  logic [CW-1:0]         accf_q, accf_d;
  logic [CW-1:0]         acch_q, acch_d;
  logic [CUW-1:0]        cur_q, cur_d;
  logic [DiskBlocks-1:0] free_q, free_d;
  logic [DiskBlocks-1:0] mask_q, mask_d;
  logic [DiskBlocks-1:0] lv_q, lv_d;

  // request and result payload
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BLK_W-1:0]  anc_q, anc_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SW-1:0]     need_q, need_d;
  logic [SW-1:0]     start_q, start_d;
  logic [SW-1:0]     len_q, len_d;
  logic [IW-1:0]     prev_q, prev_d;
  logic              ost_q, ost_d;
  logic              obv_q, obv_d;
  logic [BLK_W-1:0]  oblk_q, oblk_d;
  logic              olast_q, olast_d;

  // link table port
  logic          we;
  logic [IW-1:0] waddr;
  logic [LW-1:0] wdata;
  logic [LW-1:0] rdata;
  logic [LW-1:0] nx;

  logic [SW-1:0] cnt_s, size_s, anc_s, p_ext, p_cf, p_tk;
  logic          kb, mb, ext_bad, too_big, found, hole, in_fire, out_fire;
  logic          done, hit;
  logic          in_fresh;
  dba_req_e      req;

  assign cnt_s  = SW'(cnt_q);
  assign size_s = SW'(size_q);
  assign anc_s  = SW'(anc_q);
  assign p_ext  = anc_s + size_s + k_q;
  assign p_cf   = anc_s + k_q;
  assign p_tk   = start_q + k_q;
  assign kb     = free_q[k_q[IW-1:0]];
  assign mb     = mask_q[k_q[IW-1:0]];
  assign nx     = lv_q[cur_q[IW-1:0]] ? rdata : FreeMark;

  assign in_fire  = req_i.valid && (cmd_i.op == OP_IDLE);
  assign out_fire = ov_q && rsp_o.ready;
  assign in_fresh = (req_i.kind == KIND_ALLOC) || (req_i.current_size == '0);

  always_comb begin
    req = REQ_NONE;
    if ((kind_q == KIND_ALLOC || kind_q == KIND_EXTEND) && cnt_q != '0) begin
      if (mode_q == MODE_CONTIG) begin
        req = fresh_q ? REQ_CFIT : REQ_CEXT;
      end else begin
        req = (cnt_s > SW'(fc_q)) ? REQ_FAIL : REQ_LTAKE;
      end
    end else if (kind_q == KIND_FREE && size_q != '0) begin
      req = (mode_q == MODE_CONTIG) ? REQ_CFREE : REQ_WALK;
    end
  end

  always_comb begin
    mode_d      = cfg_we_i ? cfg_wdata_i : mode_q;
    fresh_d     = fresh_q;
    fail_d      = fail_q;
    reloc_d     = reloc_q;
    have_prev_d = have_prev_q;
    pbit_d      = pbit_q;
    ov_d        = ov_q;
    k_d         = k_q;
    run_d       = run_q;
    n_d         = n_q;
    e_d         = e_q;
    steps_d     = steps_q;
    fc_d        = fc_q;
    hc_d        = hc_q;
    accf_d      = accf_q;
    acch_d      = acch_q;
    cur_d       = cur_q;
    free_d      = free_q;
    mask_d      = mask_q;
    lv_d        = lv_q;
    kind_d      = kind_q;
    cnt_d       = cnt_q;
    anc_d       = anc_q;
    size_d      = size_q;
    need_d      = need_q;
    start_d     = start_q;
    len_d       = len_q;
    prev_d      = prev_q;
    ost_d       = ost_q;
    obv_d       = obv_q;
    oblk_d      = oblk_q;
    olast_d     = olast_q;
    we          = 1'b0;
    waddr       = prev_q;
    wdata       = EndMark;
    done        = 1'b0;
    hit         = 1'b0;
    ext_bad     = 1'b0;
    too_big     = 1'b0;
    found       = 1'b0;
    hole        = 1'b0;

    case (cmd_i.op)
      OP_IDLE: begin
        k_d = '0;
        if (in_fire) begin
          kind_d      = req_i.kind;
          cnt_d       = req_i.block_count;
          anc_d       = req_i.anchor_block;
          size_d      = req_i.current_size;
          fresh_d     = in_fresh;
          need_d      = in_fresh ? SW'(req_i.block_count)
                                 : SW'(req_i.block_count) + SW'(req_i.current_size);
          fail_d      = 1'b0;
          reloc_d     = 1'b0;
          n_d         = '0;
          e_d         = '0;
          have_prev_d = 1'b0;
          run_d       = '0;
          steps_d     = '0;
          cur_d       = CUW'(req_i.anchor_block);
        end
      end
      OP_FAIL: fail_d = 1'b1;
      OP_EXTCHK: begin
        ext_bad = (p_ext >= NBlk) || !free_q[p_ext[IW-1:0]];
        done    = ext_bad || (k_q == cnt_s - 1'b1);
        hit     = ext_bad;
        if (done && !ext_bad) begin
          start_d = anc_s + size_s;
          len_d   = cnt_s;
        end
      end
      OP_FIT: begin
        too_big = need_q > NBlk;
        found   = !too_big && kb && (run_q + 1'b1 == need_q);
        done    = too_big || found || (k_q == NLast);
        hit     = found;
        if (kb) begin
          run_d = run_q + 1'b1;
          if (run_q == '0) start_d = k_q;
        end else begin
          run_d = '0;
        end
        if (found) begin
          len_d   = need_q;
          reloc_d = !fresh_q;
        end
        if (done && !found) fail_d = 1'b1;
      end
      OP_CFREE: begin
        if (p_cf < NBlk) free_d[p_cf[IW-1:0]] = 1'b1;
        done = (k_q == size_s - 1'b1);
      end
      OP_TAKE: begin
        free_d[p_tk[IW-1:0]] = 1'b0;
        mask_d[p_tk[IW-1:0]] = 1'b1;
        done = (k_q == len_q - 1'b1);
        if (done) n_d = CW'(len_q);
      end
      OP_LTAKE: begin
        if (kb) begin
          free_d[k_q[IW-1:0]] = 1'b0;
          mask_d[k_q[IW-1:0]] = 1'b1;
          n_d         = n_q + 1'b1;
          prev_d      = k_q[IW-1:0];
          have_prev_d = 1'b1;
          // first new block hangs off the old tail, later ones off the previous
          we    = have_prev_q || (!fresh_q && anc_s < NBlk);
          waddr = have_prev_q ? prev_q : anc_q[IW-1:0];
          wdata = LW'(k_q);
        end
        done = (k_q == NLast) || (kb && (SW'(n_q) + 1'b1 == cnt_s));
      end
      OP_LEND: begin
        we    = 1'b1;
        waddr = prev_q;
        wdata = EndMark;
      end
      OP_WREAD: begin
        done = (SW'(cur_q) >= NBlk) || (steps_q == CW'(DiskBlocks));
      end
      OP_WSTEP: begin
        free_d[cur_q[IW-1:0]] = 1'b1;
        we      = 1'b1;
        waddr   = cur_q[IW-1:0];
        wdata   = FreeMark;
        cur_d   = CUW'(nx);
        steps_d = steps_q + 1'b1;
      end
      OP_COUNT: begin
        hole   = kb && !pbit_q;
        accf_d = accf_q + CW'(kb);
        acch_d = acch_q + CW'(hole);
        pbit_d = kb;
        done   = (k_q == NLast);
        if (done) begin
          fc_d   = accf_q + CW'(kb);
          hc_d   = acch_q + CW'(hole);
          accf_d = '0;
          acch_d = '0;
          pbit_d = 1'b0;
        end
      end
      OP_EMIT: begin
        if (n_q == '0) begin
          hit     = 1'b1;
          ov_d    = 1'b1;
          ost_d   = fail_q;
          obv_d   = 1'b0;
          oblk_d  = '0;
          olast_d = 1'b1;
        end else begin
          k_d = k_q + 1'b1;
          if (mb) begin
            hit     = 1'b1;
            ov_d    = 1'b1;
            ost_d   = 1'b0;
            obv_d   = 1'b1;
            oblk_d  = BLK_W'(k_q);
            olast_d = ((CW + 1)'(e_q) + 1'b1 == (CW + 1)'(n_q));
            e_d     = e_q + 1'b1;
            mask_d[k_q[IW-1:0]] = 1'b0;
          end
        end
      end
      OP_EWAIT: begin
        if (out_fire) ov_d = 1'b0;
      end
      default: ;
    endcase

    // scan counter restarts after each finished pass
    if (cmd_i.op == OP_EXTCHK || cmd_i.op == OP_FIT || cmd_i.op == OP_CFREE ||
        cmd_i.op == OP_TAKE || cmd_i.op == OP_LTAKE || cmd_i.op == OP_COUNT) begin
      k_d = done ? '0 : k_q + 1'b1;
    end

    if (we) lv_d[waddr] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CONTIG;
      fresh_q     <= 1'b0;
      fail_q      <= 1'b0;
      reloc_q     <= 1'b0;
      have_prev_q <= 1'b0;
      pbit_q      <= 1'b0;
      ov_q        <= 1'b0;
      k_q         <= '0;
      run_q       <= '0;
      n_q         <= '0;
      e_q         <= '0;
      steps_q     <= '0;
      fc_q        <= CW'(DiskBlocks);
      hc_q        <= CW'(1);
      accf_q      <= '0;
      acch_q      <= '0;
      cur_q       <= '0;
      free_q      <= '1;
      mask_q      <= '0;
      lv_q        <= '0;
    end else begin
      mode_q      <= mode_d;
      fresh_q     <= fresh_d;
      fail_q      <= fail_d;
      reloc_q     <= reloc_d;
      have_prev_q <= have_prev_d;
      pbit_q      <= pbit_d;
      ov_q        <= ov_d;
      k_q         <= k_d;
      run_q       <= run_d;
      n_q         <= n_d;
      e_q         <= e_d;
      steps_q     <= steps_d;
      fc_q        <= fc_d;
      hc_q        <= hc_d;
      accf_q      <= accf_d;
      acch_q      <= acch_d;
      cur_q       <= cur_d;
      free_q      <= free_d;
      mask_q      <= mask_d;
      lv_q        <= lv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    cnt_q   <= cnt_d;
    anc_q   <= anc_d;
    size_q  <= size_d;
    need_q  <= need_d;
    start_q <= start_d;
    len_q   <= len_d;
    prev_q  <= prev_d;
    ost_q   <= ost_d;
    obv_q   <= obv_d;
    oblk_q  <= oblk_d;
    olast_q <= olast_d;
  end

  // unwritten links read as the free marker through lv_q
  dba_ram #(
    .Width (LW),
    .Depth (DiskBlocks)
  ) u_link (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (cur_q[IW-1:0]),
    .rdata_o (rdata)
  );

  assign req_i.ready       = (cmd_i.op == OP_IDLE);
  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = ost_q;
  assign rsp_o.block_valid = obv_q;
  assign rsp_o.block       = oblk_q;
  assign rsp_o.last        = olast_q;
  assign rsp_o.free_count  = FC_W'(fc_q);
  assign rsp_o.hole_count  = HC_W'(hc_q);

  assign sts_o.req      = req;
  assign sts_o.in_fire  = in_fire;
  assign sts_o.done     = done;
  assign sts_o.hit      = hit;
  assign sts_o.fresh    = fresh_q;
  assign sts_o.reloc    = reloc_q;
  assign sts_o.out_fire = out_fire;
  assign sts_o.out_last = olast_q;

  a_out_only_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> cmd_i.op == OP_EWAIT) else $error("result held outside wait state");

  a_free_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CW'(DiskBlocks)) else $error("free count above disk size");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_q <= n_q) else $error("more blocks sent than taken");

  a_tail_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_LEND |-> have_prev_q) else $error("chain end without a block");

endmodule

// File: design/disk_block_allocator_unit.sv
// Block allocator over a disk of DiskBlocks blocks, kept as a free bitmap plus a
// next-link table (one write port, registered read). In contiguous mode requests
// use first-fit runs; in linked mode the lowest free blocks are chained in
// ascending order. One request is handled at a time. The bitmap is worked one
// block per cycle in the in-place extend check, first-fit scan, release and
// take passes; a chain free reads each link from the registered link RAM
// before it steps to the next, and every request ends with a pass that counts
// free blocks and holes. Blocks are then sent in file order, each result held
// until the sink takes it; the next request is accepted once the last result
// of the current one has been taken.
module disk_block_allocator_unit #(
  parameter int DiskBlocks = dba_pkg::DISK_BLOCKS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  dba_req_if.sink   req_i,
  dba_rsp_if.source rsp_o
);
  import dba_pkg::*;

  dba_cmd_t cmd;
  dba_sts_t sts;

  dba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  dba_dp #(
    .DiskBlocks (DiskBlocks)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .rsp_o       (rsp_o)
  );

endmodule
